// File: hw/rtl/telnet_iac_stream_filter_macros.svh
// Assertion macros shared by the telnet stream filter RTL.
// Depends on nothing; assertions drop out when SYNTHESIS is defined.
`ifndef TELNET_IAC_STREAM_FILTER_MACROS_SVH
`define TELNET_IAC_STREAM_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// implication or plain property, checked on every rising edge out of reset
`define TISF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
// condition that must never hold
`define TISF_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define TISF_ASSERT(label, clk, rst_n, prop)
`define TISF_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: hw/rtl/tisf_pkg.sv
// Package for the telnet stream filter: byte codes, parser states, count limit
// and the result struct passed from the parser to the top level.
// Depends on nothing.
package tisf_pkg;

	localparam int unsigned MAX_BUFFER = 4096;
	localparam int unsigned COUNT_W    = 13;
	localparam int unsigned COUNT_MAX  = (1 << COUNT_W) - 1;
	localparam int unsigned LIMIT_INT  = (MAX_BUFFER > COUNT_MAX) ? COUNT_MAX : MAX_BUFFER;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LIMIT_INT);

	localparam logic [7:0] CODE_IAC = 8'd255;
	localparam logic [7:0] CODE_SB  = 8'd250;
	localparam logic [7:0] CODE_SE  = 8'd240;
	localparam logic [7:0] CODE_CR  = 8'd13;
	localparam logic [7:0] CODE_LF  = 8'd10;
	localparam logic [7:0] CODE_NUL = 8'd0;

	localparam int unsigned STATE_W = 3;
	localparam logic [STATE_W-1:0] PS_IDLE   = 3'd0;
	localparam logic [STATE_W-1:0] PS_IAC    = 3'd1;
	localparam logic [STATE_W-1:0] PS_ARG    = 3'd2;
	localparam logic [STATE_W-1:0] PS_SB     = 3'd3;
	localparam logic [STATE_W-1:0] PS_SB_IAC = 3'd4;
	localparam logic [STATE_W-1:0] PS_CR     = 3'd5;

	typedef struct packed {
		logic               valid;      // a result beat is due for this byte
		logic [7:0]         data;
		logic               byte_valid;
		logic               last;
		logic [COUNT_W-1:0] count;
	} res_t;

endpackage

// File: hw/rtl/telnet_iac_stream_filter.sv
// Telnet IAC stream filter: input register, parser, result register.
// Throughput: one byte per cycle unless out_stall holds a full result register;
// the parse state is updated as the byte leaves the input register, so consecutive bytes need no gap.
// Reset: arst_n clears both stage valids, the parse state and the byte count.
// Depends on tisf_pkg, tisf_parse and the macros header.
`include "telnet_iac_stream_filter_macros.svh"

module telnet_iac_stream_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_in,
	input  logic                          last_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    data_out,
	output logic                          byte_valid,
	output logic                          last_out,
	output logic [tisf_pkg::COUNT_W-1:0]  out_count
);

	logic                          vld_s1;
	logic [7:0]                    data_s1;
	logic                          last_s1;
	logic                          vld_s2;
	logic [7:0]                    data_s2;
	logic                          bvalid_s2;
	logic                          last_s2;
	logic [tisf_pkg::COUNT_W-1:0]  count_s2;

	logic           s2_free;
	logic           step;
	tisf_pkg::res_t res;

	assign s2_free  = !vld_s2 || !out_stall;
	assign step     = vld_s1 && s2_free;
	assign in_stall = vld_s1 && !s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (!in_stall)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_in;
			last_s1 <= last_in;
		end
	end

	tisf_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.data   (data_s1),
		.last   (last_s1),
		.res    (res)
	);

	// bytes that give no result leave stage 1 without filling stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (s2_free)
			vld_s2 <= step && res.valid;
	end

	always_ff @(posedge clk) begin
		if (step && res.valid && s2_free) begin
			data_s2   <= res.data;
			bvalid_s2 <= res.byte_valid;
			last_s2   <= res.last;
			count_s2  <= res.count;
		end
	end

	assign out_valid  = vld_s2;
	assign data_out   = data_s2;
	assign byte_valid = bvalid_s2;
	assign last_out   = last_s2;
	assign out_count  = count_s2;

	`TISF_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> out_valid && out_stall)
	`TISF_ASSERT(a_end_only, clk, arst_n, out_valid && !byte_valid |-> last_out && data_out == tisf_pkg::CODE_NUL)
	`TISF_ASSERT(a_count_nz, clk, arst_n, out_valid && byte_valid |-> out_count != '0)

endmodule

// File: hw/rtl/tisf_parse.sv
// Telnet command parser: state and emitted-byte count, next-state logic and
// result formation for one byte. Depends on tisf_pkg and the macros header.
`include "telnet_iac_stream_filter_macros.svh"

module tisf_parse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data,
	input  logic                   last,
	output tisf_pkg::res_t         res
);

	logic [tisf_pkg::STATE_W-1:0] state_q;
	logic [tisf_pkg::STATE_W-1:0] state_nxt;
	logic [tisf_pkg::COUNT_W-1:0] cnt_q;
	logic [tisf_pkg::COUNT_W-1:0] cnt_nxt;

	logic [tisf_pkg::STATE_W-1:0] idle_nxt;
	logic                         idle_have;
	logic [7:0]                   idle_emit;
	logic                         have;
	logic [7:0]                   emit;

	// plain data byte handling, shared by idle and the state after CR
	always_comb begin
		idle_nxt  = tisf_pkg::PS_IDLE;
		idle_have = 1'b0;
		idle_emit = tisf_pkg::CODE_NUL;
		if (data == tisf_pkg::CODE_IAC) begin
			idle_nxt = tisf_pkg::PS_IAC;
		end else if (data == tisf_pkg::CODE_CR) begin
			idle_nxt  = tisf_pkg::PS_CR;
			idle_have = 1'b1;
			idle_emit = tisf_pkg::CODE_LF;
		end else if (data != tisf_pkg::CODE_NUL) begin
			idle_have = 1'b1;
			idle_emit = data;
		end
	end

	always_comb begin
		state_nxt = state_q;
		have      = 1'b0;
		emit      = tisf_pkg::CODE_NUL;
		case (state_q)
			tisf_pkg::PS_IAC: begin
				if (data == tisf_pkg::CODE_IAC) begin
					have      = 1'b1;
					emit      = tisf_pkg::CODE_IAC;
					state_nxt = tisf_pkg::PS_IDLE;
				end else if (data == tisf_pkg::CODE_SB) begin
					state_nxt = tisf_pkg::PS_SB;
				end else begin
					state_nxt = tisf_pkg::PS_ARG;
				end
			end
			tisf_pkg::PS_ARG: begin
				state_nxt = tisf_pkg::PS_IDLE;
			end
			tisf_pkg::PS_SB: begin
				if (data == tisf_pkg::CODE_IAC)
					state_nxt = tisf_pkg::PS_SB_IAC;
			end
			tisf_pkg::PS_SB_IAC: begin
				// a repeated IAC may still open the terminator
				if (data == tisf_pkg::CODE_SE)
					state_nxt = tisf_pkg::PS_IDLE;
				else if (data != tisf_pkg::CODE_IAC)
					state_nxt = tisf_pkg::PS_SB;
			end
			tisf_pkg::PS_CR: begin
				if (data inside {tisf_pkg::CODE_LF, tisf_pkg::CODE_NUL}) begin
					state_nxt = tisf_pkg::PS_IDLE;
				end else begin
					state_nxt = idle_nxt;
					have      = idle_have;
					emit      = idle_emit;
				end
			end
			default: begin
				state_nxt = idle_nxt;
				have      = idle_have;
				emit      = idle_emit;
			end
		endcase
	end

	// count saturates at the buffer limit
	assign cnt_nxt = (have && (cnt_q < tisf_pkg::COUNT_LIMIT)) ?
		cnt_q + tisf_pkg::COUNT_W'(1) : cnt_q;

	assign res.valid      = have | last;
	assign res.data       = have ? emit : tisf_pkg::CODE_NUL;
	assign res.byte_valid = have;
	assign res.last       = last;
	assign res.count      = cnt_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tisf_pkg::PS_IDLE;
			cnt_q   <= '0;
		end else if (step) begin
			if (last) begin
				state_q <= tisf_pkg::PS_IDLE;
				cnt_q   <= '0;
			end else begin
				state_q <= state_nxt;
				cnt_q   <= cnt_nxt;
			end
		end
	end

	`TISF_NEVER(a_cnt_limit, clk, arst_n, cnt_q > tisf_pkg::COUNT_LIMIT)
	`TISF_ASSERT(a_last_clears, clk, arst_n, step && last |=> state_q == tisf_pkg::PS_IDLE && cnt_q == '0)
	`TISF_ASSERT(a_cnt_step, clk, arst_n, step && !last |=> cnt_q - $past(cnt_q) <= tisf_pkg::COUNT_W'(1))
	`TISF_ASSERT(a_ff_from_iac, clk, arst_n, have && emit == tisf_pkg::CODE_IAC |-> state_q == tisf_pkg::PS_IAC)

endmodule
